// ----- hw/rtl/execution_time_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the execution time statistics block
// Clocked, reset-qualified property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EXECUTION_TIME_STATISTICS_MACROS_SVH
`define EXECUTION_TIME_STATISTICS_MACROS_SVH

// Same-cycle implication.
`define ETS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ETS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ets_pkg.sv -----
// ----------------------------------------------------------------------------
// ets_pkg
// Shared types and constants for the execution time statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package ets_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [DATA_W-1:0] SAT_MAX = {DATA_W{1'b1}};

  // Item command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] last_value;
    logic [DATA_W-1:0] min_value;
    logic [DATA_W-1:0] max_value;
    logic [DATA_W-1:0] avg_value;
    logic [DATA_W-1:0] total_samples;
    logic [DATA_W-1:0] overrun_total;
  } stats_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ets_if.sv -----
// ----------------------------------------------------------------------------
// ets_sample_if / ets_result_if
// Valid/ready channels for sample items and statistics result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ets_sample_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [ets_pkg::DATA_W-1:0] sample_cycles;

  modport source (output valid, output cmd, output sample_cycles, input ready);
  modport sink   (input valid, input cmd, input sample_cycles, output ready);
endinterface

interface ets_result_if;
  logic                       valid;
  logic                       ready;
  logic [ets_pkg::DATA_W-1:0] last_value;
  logic [ets_pkg::DATA_W-1:0] min_value;
  logic [ets_pkg::DATA_W-1:0] max_value;
  logic [ets_pkg::DATA_W-1:0] avg_value;
  logic [ets_pkg::DATA_W-1:0] total_samples;
  logic [ets_pkg::DATA_W-1:0] overrun_total;

  modport source (
    output valid, output last_value, output min_value, output max_value,
    output avg_value, output total_samples, output overrun_total, input ready
  );
  modport sink (
    input valid, input last_value, input min_value, input max_value,
    input avg_value, input total_samples, input overrun_total, output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/ets_update.sv -----
// ----------------------------------------------------------------------------
// ets_update
// Next-state logic: applies one record or clear item to the statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_update #(
  parameter int unsigned AVG_SHIFT = 4
) (
  input  ets_pkg::stats_t             cur,
  input  logic                        cmd,
  input  logic [ets_pkg::DATA_W-1:0]  sample_cycles,
  input  logic [ets_pkg::DATA_W-1:0]  overrun_threshold,
  output ets_pkg::stats_t             nxt
);

  logic                       seed;
  logic                       above_avg;
  logic [ets_pkg::DATA_W-1:0] diff;
  logic [ets_pkg::DATA_W-1:0] step;
  logic                       overrun;

  assign seed      = (cur.total_samples == '0);
  assign above_avg = (sample_cycles >= cur.avg_value);
  assign diff      = above_avg ? (sample_cycles - cur.avg_value)
                               : (cur.avg_value - sample_cycles);
  assign step      = diff >> AVG_SHIFT;
  assign overrun   = (overrun_threshold != '0) && (sample_cycles > overrun_threshold);

  always_comb begin
    nxt = cur;
    if (cmd == ets_pkg::CMD_CLEAR) begin
      nxt = '0;
    end else begin
      nxt.last_value = sample_cycles;
      if (seed) begin
        nxt.min_value = sample_cycles;
        nxt.max_value = sample_cycles;
        nxt.avg_value = sample_cycles;
      end else begin
        if (sample_cycles < cur.min_value) nxt.min_value = sample_cycles;
        if (sample_cycles > cur.max_value) nxt.max_value = sample_cycles;
        nxt.avg_value = above_avg ? (cur.avg_value + step) : (cur.avg_value - step);
      end
      if (cur.total_samples != ets_pkg::SAT_MAX) begin
        nxt.total_samples = cur.total_samples + ets_pkg::DATA_W'(1);
      end
      if (overrun && (cur.overrun_total != ets_pkg::SAT_MAX)) begin
        nxt.overrun_total = cur.overrun_total + ets_pkg::DATA_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/execution_time_statistics.sv -----
// ----------------------------------------------------------------------------
// execution_time_statistics
// Running last/min/max/average and saturating counters over cycle counts.
// ----------------------------------------------------------------------------
// Each item on the sample channel either records a measured duration
// (cmd = record) or clears every statistic (cmd = clear); every item yields
// exactly one result item holding the statistics after that item. One item
// per cycle is sustained while results are taken: an item waits in the input
// register, passes through the update logic, and lands in the statistics
// register, which is also the result register; result valid rises when the
// statistics register takes the item. The rate is set by the single feedback
// loop through the update logic (32-bit subtracts and adds, and compares).
// A stalled result holds the statistics and, once the input register is also
// full, deasserts sample.ready. The average moves toward each sample by the
// difference shifted right by AVG_SHIFT, rounding toward the old average; the
// first sample after clear or reset seeds min, max and average. The overrun
// threshold is written through cfg_we/cfg_wdata, by the user only while the
// block is idle (not enforced by the block); a value of zero disables overrun
// counting. Reset clears all statistics and the threshold; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module execution_time_statistics #(
  parameter int unsigned AVG_SHIFT = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  ets_sample_if.sink                 sample,
  ets_result_if.source               result,
  input  logic                       cfg_we,
  input  logic [ets_pkg::DATA_W-1:0] cfg_wdata
);

  // Input register
  logic                       in_valid;
  logic                       in_cmd;
  logic [ets_pkg::DATA_W-1:0] in_sample;

  // Statistics register doubles as the result register
  ets_pkg::stats_t            stats;
  ets_pkg::stats_t            stats_next;
  logic                       out_valid;

  logic [ets_pkg::DATA_W-1:0] overrun_threshold;

  logic                       advance;

  // Move the held item into the statistics when the result slot frees up.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_cmd    <= sample.cmd;
      in_sample <= sample.sample_cycles;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overrun_threshold <= '0;
    end else if (cfg_we) begin
      overrun_threshold <= cfg_wdata;
    end
  end

  ets_update #(
    .AVG_SHIFT (AVG_SHIFT)
  ) u_update (
    .cur               (stats),
    .cmd               (in_cmd),
    .sample_cycles     (in_sample),
    .overrun_threshold (overrun_threshold),
    .nxt               (stats_next)
  );

  // Statistics are architectural state: reset clears them.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        stats <= stats_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.last_value    = stats.last_value;
  assign result.min_value     = stats.min_value;
  assign result.max_value     = stats.max_value;
  assign result.avg_value     = stats.avg_value;
  assign result.total_samples = stats.total_samples;
  assign result.overrun_total = stats.overrun_total;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "execution_time_statistics_macros.svh"

  `ETS_ASSERT_NEXT(a_clear_zeroes, clk, rst,
    advance && (in_cmd == ets_pkg::CMD_CLEAR), stats == '0,
    "clear item did not zero the statistics")

  `ETS_ASSERT_NEXT(a_count_step, clk, rst,
    advance && (in_cmd == ets_pkg::CMD_RECORD) && (stats.total_samples != ets_pkg::SAT_MAX),
    stats.total_samples == $past(stats.total_samples) + ets_pkg::DATA_W'(1),
    "sample counter did not step on a record item")

  `ETS_ASSERT_NOW(a_avg_bounded, clk, rst,
    stats.total_samples != '0,
    (stats.min_value <= stats.avg_value) && (stats.avg_value <= stats.max_value),
    "average left the min/max range")

  `ETS_ASSERT_NEXT(a_overrun_seen, clk, rst,
    advance && (in_cmd == ets_pkg::CMD_RECORD) && (overrun_threshold != '0)
      && (in_sample > overrun_threshold),
    stats.overrun_total != '0,
    "overrun sample not counted")

endmodule

`default_nettype wire

// ----- test/execution_time_statistics_test.sv -----
// ----------------------------------------------------------------------------
// execution_time_statistics_test
// Self-checking bench for the running min/max/average statistics block.
// Sample items (record or clear) go in through a bursty driver; result items
// are taken by a monitor whose ready stalls in changing patterns. A built-in
// predictor tracks the statistics and checks every result field. The overrun
// threshold is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module execution_time_statistics_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AVG_WEIGHT_SHIFT = 4;
  localparam int STALL_LIMIT      = 2000;   // cycles with no item moving
  localparam int ITEMS_PER_PHASE  = 240;

  typedef logic [ets_pkg::DATA_W-1:0] word_t;

  typedef struct {
    logic  cmd;
    word_t cycles;
  } sample_item_t;

  logic  clk;
  logic  rst;
  logic  cfg_we;
  word_t cfg_wdata;

  ets_sample_if sample_ch ();
  ets_result_if result_ch ();

  execution_time_statistics #(.AVG_SHIFT(AVG_WEIGHT_SHIFT)) dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: the statistics as they stand after every accepted item,
  // plus our own copy of the threshold register.
  // --------------------------------------------------------------------------
  ets_pkg::stats_t tally;
  word_t           overrun_limit;

  sample_item_t    pending_items[$];   // filled by the stimulus, drained by driver
  ets_pkg::stats_t expected_stats[$];  // one entry per accepted item, oldest first

  sample_item_t cur_item;
  bit           item_loaded;        // driver holds an item not yet accepted
  int           burst_left;
  int           gap_left;
  int           mismatch_count;
  int           quiet_cycles;

  // Statistics after one item. A clear wipes everything but the threshold;
  // the first record after a clear seeds min, max and average.
  function automatic ets_pkg::stats_t next_statistics(sample_item_t it);
    word_t s;
    s = it.cycles;
    if (it.cmd == ets_pkg::CMD_CLEAR) begin
      tally = '0;
    end else begin
      tally.last_value = s;
      if (tally.total_samples == '0) begin
        tally.min_value = s;
        tally.max_value = s;
        tally.avg_value = s;
      end else begin
        if (s < tally.min_value) tally.min_value = s;
        if (s > tally.max_value) tally.max_value = s;
        // Step toward the sample; the truncated shift rounds toward the
        // old average from either side.
        if (s >= tally.avg_value) begin
          tally.avg_value = tally.avg_value + ((s - tally.avg_value) >> AVG_WEIGHT_SHIFT);
        end else begin
          tally.avg_value = tally.avg_value - ((tally.avg_value - s) >> AVG_WEIGHT_SHIFT);
        end
      end
      if (tally.total_samples != ets_pkg::SAT_MAX) tally.total_samples++;
      // Zero threshold disables overrun counting; strictly above counts.
      if (overrun_limit != '0 && s > overrun_limit
          && tally.overrun_total != ets_pkg::SAT_MAX) begin
        tally.overrun_total++;
      end
    end
    return tally;
  endfunction

  task automatic compare_field(string label, word_t want, word_t got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%08h) actual %0d (0x%08h)",
               $time, label, want, want, got, got);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: one item at a time from pending_items, in bursts of random length
  // separated by random gaps. valid gets exactly one NBA per edge, so a held
  // or back-to-back item never sees valid dip within a time step.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      item_loaded = 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        expected_stats.push_back(next_statistics(cur_item));
        item_loaded = 1'b0;
      end
      if (!item_loaded) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item    = pending_items.pop_front();
          item_loaded = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // Occasional long burst gives stretches with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      sample_ch.valid         <= item_loaded;
      sample_ch.cmd           <= cur_item.cmd;
      sample_ch.sample_cycles <= cur_item.cycles;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: ready follows a pattern that changes every so often (always
  // ready, coin flip, one cycle in four, rare stalls). Every accepted result
  // is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  int stall_mode;
  int mode_cycles;
  int pattern_phase;

  always @(posedge clk) begin
    ets_pkg::stats_t want;
    logic            take;
    if (result_ch.valid && result_ch.ready) begin
      if (expected_stats.size() == 0) begin
        $display("%0t ns: result item with no expectation pending", $time);
        mismatch_count++;
      end else begin
        want = expected_stats.pop_front();
        compare_field("last_value",    want.last_value,    result_ch.last_value);
        compare_field("min_value",     want.min_value,     result_ch.min_value);
        compare_field("max_value",     want.max_value,     result_ch.max_value);
        compare_field("avg_value",     want.avg_value,     result_ch.avg_value);
        compare_field("total_samples", want.total_samples, result_ch.total_samples);
        compare_field("overrun_total", want.overrun_total, result_ch.overrun_total);
      end
    end
    if (mode_cycles == 0) begin
      stall_mode  = $urandom_range(0, 3);
      mode_cycles = $urandom_range(20, 200);
    end else begin
      mode_cycles--;
    end
    pattern_phase = (pattern_phase + 1) % 4;
    case (stall_mode)
      0:       take = 1'b1;
      1:       take = 1'($urandom_range(0, 1));
      2:       take = (pattern_phase == 0);
      default: take = ($urandom_range(0, 7) != 0);
    endcase
    result_ch.ready <= take;
  end

  // Watchdog: a correct run never goes long without an item moving.
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_item(logic cmd, word_t cycles);
    sample_item_t it;
    it.cmd    = cmd;
    it.cycles = cycles;
    pending_items.push_back(it);
  endtask

  // Block is idle once nothing is queued, held or awaiting its result.
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_loaded || expected_stats.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Only called while drained; the predictor copy changes with the register.
  task automatic write_threshold(word_t value);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= value;
    overrun_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sample values spread over magnitudes, with weight near the threshold and
  // the field extremes so overrun edges and min/max updates get hit.
  function automatic word_t random_cycles(word_t thr);
    word_t v;
    case ($urandom_range(0, 9))
      0, 8: v = $urandom;
      1: begin
        v = thr + $urandom_range(0, 4);
        v = v - 2;
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = 1;
          2:       v = ets_pkg::SAT_MAX - 1;
          default: v = ets_pkg::SAT_MAX;
        endcase
      end
      7:       v = 1000000 - 50000 + $urandom_range(0, 100000);
      9:       v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom_range(500, 2000);
    endcase
    return v;
  endfunction

  // Mostly runs of records with an occasional clear, so averages settle and
  // reseeding after clear keeps getting exercised.
  task automatic random_phase(word_t thr, int count);
    repeat (count) begin
      if ($urandom_range(0, 24) == 0) begin
        add_item(ets_pkg::CMD_CLEAR, $urandom);
      end else begin
        add_item(ets_pkg::CMD_RECORD, random_cycles(thr));
      end
    end
    wait_drained();
  endtask

  word_t phase_limits[6];

  initial begin
    clk                     = 1'b0;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_wdata               = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.cmd           = ets_pkg::CMD_RECORD;
    sample_ch.sample_cycles = '0;
    result_ch.ready         = 1'b0;
    tally                   = '0;
    overrun_limit           = '0;
    cur_item                = '{cmd: ets_pkg::CMD_RECORD, cycles: '0};
    item_loaded             = 1'b0;
    burst_left              = 0;
    gap_left                = 0;
    mismatch_count          = 0;
    quiet_cycles            = 0;
    stall_mode              = 0;
    mode_cycles             = 0;
    pattern_phase           = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed, threshold at its reset value of zero: overruns never count,
    // even for the largest sample.
    add_item(ets_pkg::CMD_RECORD, '0);              // seed with zero
    add_item(ets_pkg::CMD_RECORD, ets_pkg::SAT_MAX); // max jumps, average climbs by 1/16
    add_item(ets_pkg::CMD_RECORD, 1);
    add_item(ets_pkg::CMD_CLEAR,  ets_pkg::SAT_MAX); // sample field ignored on clear
    add_item(ets_pkg::CMD_RECORD, ets_pkg::SAT_MAX); // reseed at the top of the range
    add_item(ets_pkg::CMD_RECORD, '0);              // average falls from the top
    add_item(ets_pkg::CMD_RECORD, 15);
    add_item(ets_pkg::CMD_CLEAR,  '0);
    add_item(ets_pkg::CMD_CLEAR,  32'h5555_5555);   // back-to-back clears
    add_item(ets_pkg::CMD_RECORD, 100);
    add_item(ets_pkg::CMD_RECORD, 115);             // difference below 16: average holds
    add_item(ets_pkg::CMD_RECORD, 85);
    add_item(ets_pkg::CMD_RECORD, 32'hAAAA_AAAA);
    add_item(ets_pkg::CMD_RECORD, 32'h5555_5555);
    wait_drained();

    // Directed around a nonzero threshold: equal does not count, above does.
    write_threshold(1000000);
    add_item(ets_pkg::CMD_RECORD, 1000000);
    add_item(ets_pkg::CMD_RECORD, 1000001);
    add_item(ets_pkg::CMD_RECORD, ets_pkg::SAT_MAX);
    add_item(ets_pkg::CMD_RECORD, 999999);
    add_item(ets_pkg::CMD_CLEAR,  '0);              // overrun count cleared, threshold kept
    add_item(ets_pkg::CMD_RECORD, 1000002);
    wait_drained();

    // Random phases across threshold settings, extremes included.
    phase_limits[0] = ets_pkg::SAT_MAX;     // nothing can exceed it
    phase_limits[1] = 1;
    phase_limits[2] = ets_pkg::SAT_MAX - 1; // only the all-ones sample exceeds it
    phase_limits[3] = $urandom;
    phase_limits[4] = '0;                   // overrun counting disabled again
    phase_limits[5] = $urandom_range(100, 5000);
    foreach (phase_limits[i]) begin
      write_threshold(phase_limits[i]);
      random_phase(phase_limits[i], ITEMS_PER_PHASE);
    end

    // Let any stray result show up before judging.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_stats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ets_pkg.sv
hw/rtl/ets_if.sv
hw/rtl/ets_update.sv
hw/rtl/execution_time_statistics.sv
test/execution_time_statistics_test.sv
